// ----- hw/rtl/embedding_row_address_gen_core_defines.svh -----
// Assertion helpers used by erag_back; they expect clock and reset in scope.
`ifndef EMBEDDING_ROW_ADDRESS_GEN_CORE_DEFINES_SVH
`define EMBEDDING_ROW_ADDRESS_GEN_CORE_DEFINES_SVH

// Same-cycle implication.
`define ERAG_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("erag: same-cycle check failed");

// Next-cycle implication.
`define ERAG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("erag: next-cycle check failed");

`endif

// ----- hw/rtl/erag_pkg.sv -----
`default_nettype none

package erag_pkg;

   localparam int MAX_TABLES   = 1024;
   localparam int TABLE_AW     = $clog2(MAX_TABLES);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_TABLES_W = 11;
   localparam int EMBED_DIM_W  = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int DIV_STEPS    = 32;
   localparam int DIV_CW       = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TABLES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMBED_DIM  = 1'b1;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  table_number;
      logic [30:0] position_value;
      logic [31:0] weight_offset;
      logic [30:0] index_value;
   } req_type;

   typedef struct packed {
      logic [32:0] row_index;
      logic [9:0]  table_id;
      logic        miss;
      logic [30:0] out_position;
   } rsp_type;

   // classified command; loads carry the finished row base
   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  table_number;
      logic [30:0] position_value;
      logic [31:0] row_base;
      logic [30:0] index_value;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [30:0] start;
      logic [31:0] row_base;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ----- hw/rtl/erag_ram.sv -----
`default_nettype none

module erag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/erag_front.sv -----
`default_nettype none

module erag_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire erag_pkg::req_type                   req_payload,
   output logic                                     busy,
   input  wire logic [erag_pkg::EMBED_DIM_W-1:0]    embed_dim,
   input  wire erag_pkg::queue_status_type          q_status,
   output logic                                     q_push,
   output erag_pkg::cmd_type                        q_push_data
);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} state_type;

   state_type                          state_ff, state_in;
   logic [erag_pkg::DIV_CW-1:0]        cnt_ff, cnt_in;
   logic [erag_pkg::EMBED_DIM_W-1:0]   rem_ff, rem_in;
   logic [31:0]                        quo_ff, quo_in;
   logic [erag_pkg::EMBED_DIM_W-1:0]   dvs_ff, dvs_in;
   erag_pkg::cmd_type                  hold_ff, hold_in;

   logic                               accept;
   logic [erag_pkg::EMBED_DIM_W:0]     shifted;
   logic [erag_pkg::EMBED_DIM_W:0]     diff;
   logic                               ge;

   assign busy   = (state_ff != D_IDLE) || q_status.full;
   assign accept = start && !busy;

   // restoring divide, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      hold_in     = hold_ff;
      q_push      = 1'b0;
      q_push_data = '0;
      case (state_ff)
         D_IDLE: begin
            if (accept) begin
               if (req_payload.func == erag_pkg::FUNC_LOAD) begin
                  hold_in.func           = req_payload.func;
                  hold_in.table_number   = req_payload.table_number;
                  hold_in.position_value = req_payload.position_value;
                  hold_in.row_base       = '0;
                  hold_in.index_value    = req_payload.index_value;
                  quo_in   = req_payload.weight_offset;
                  rem_in   = '0;
                  cnt_in   = '0;
                  dvs_in   = (embed_dim == '0) ? erag_pkg::EMBED_DIM_W'(1) : embed_dim;
                  state_in = D_RUN;
               end else if (req_payload.func inside {erag_pkg::FUNC_LOOKUP,
                                                     erag_pkg::FUNC_RESTART}) begin
                  q_push                     = 1'b1;
                  q_push_data.func           = req_payload.func;
                  q_push_data.table_number   = req_payload.table_number;
                  q_push_data.position_value = req_payload.position_value;
                  q_push_data.row_base       = '0;
                  q_push_data.index_value    = req_payload.index_value;
               end
            end
         end
         D_RUN: begin
            rem_in = ge ? diff[erag_pkg::EMBED_DIM_W-1:0]
                        : shifted[erag_pkg::EMBED_DIM_W-1:0];
            quo_in = {quo_ff[30:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == erag_pkg::DIV_CW'(erag_pkg::DIV_STEPS - 1)) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            if (!q_status.full) begin
               q_push               = 1'b1;
               q_push_data          = hold_ff;
               q_push_data.row_base = quo_ff;
               state_in             = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      hold_ff <= hold_in;
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/erag_queue.sv -----
`default_nettype none

module erag_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire erag_pkg::cmd_type           push_data,
   input  wire logic                        pop,
   output erag_pkg::queue_status_type       status,
   output erag_pkg::cmd_type                head
);

   erag_pkg::cmd_type                 slot_ff [erag_pkg::QUEUE_DEPTH];
   logic [erag_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [erag_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [erag_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == erag_pkg::QUEUE_CW'(erag_pkg::QUEUE_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/erag_back.sv -----
`default_nettype none

`include "embedding_row_address_gen_core_defines.svh"

module erag_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [erag_pkg::NUM_TABLES_W-1:0]   num_tables,
   input  wire erag_pkg::queue_status_type          q_status,
   input  wire erag_pkg::cmd_type                   q_head,
   output logic                                     q_pop,
   output logic                                     rsp_strobe,
   output erag_pkg::rsp_type                        rsp_payload
);

   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_BASE} state_type;

   state_type                          state_ff, state_in;
   logic [erag_pkg::TABLE_AW-1:0]      cur_ff, cur_in;
   logic [30:0]                        pos_ff, pos_in;
   logic [30:0]                        start0_ff, start0_in;
   logic [30:0]                        idx_ff, idx_in;
   logic [31:0]                        base_ff, base_in;
   logic                               base_ok_ff, base_ok_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   erag_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                               ram_wr_en;
   logic [erag_pkg::TABLE_AW-1:0]      ram_wr_addr;
   erag_pkg::entry_type                ram_wr_data;
   logic                               ram_rd_en;
   logic [erag_pkg::TABLE_AW-1:0]      ram_rd_addr;
   erag_pkg::entry_type                ram_rd_data;

   // walk: continue a lookup from table walk_cur
   logic                               walk;
   logic                               walk_search;
   logic [erag_pkg::TABLE_AW-1:0]      walk_cur;
   logic                               walk_ok;
   logic [31:0]                        walk_base;
   logic [30:0]                        walk_idx;
   logic [erag_pkg::TABLE_AW-1:0]      clamp_cur;
   logic                               clamp_hit;
   logic                               tables_ok;

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign tables_ok = (num_tables != '0) && (32'(num_tables) <= erag_pkg::MAX_TABLES);
   assign clamp_hit = 32'(cur_ff) >= 32'(num_tables);
   assign clamp_cur = clamp_hit ? erag_pkg::TABLE_AW'(32'(num_tables) - 1) : cur_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      start0_in    = start0_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      base_ok_in   = base_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = erag_pkg::TABLE_AW'(q_head.table_number);
      ram_wr_data  = {q_head.position_value, q_head.row_base};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      walk         = 1'b0;
      walk_search  = 1'b1;
      walk_cur     = cur_ff;
      walk_ok      = base_ok_ff;
      walk_base    = base_ff;
      walk_idx     = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_status.valid) begin
               q_pop = 1'b1;
               case (q_head.func)
                  erag_pkg::FUNC_LOAD: begin
                     if (32'(q_head.table_number) < erag_pkg::MAX_TABLES) begin
                        ram_wr_en  = 1'b1;
                        base_ok_in = 1'b0;
                        if (q_head.table_number == '0) begin
                           start0_in = q_head.position_value;
                        end
                     end
                  end
                  erag_pkg::FUNC_RESTART: begin
                     pos_in     = q_head.position_value;
                     cur_in     = '0;
                     base_ok_in = 1'b0;
                  end
                  erag_pkg::FUNC_LOOKUP: begin
                     if (tables_ok) begin
                        idx_in     = q_head.index_value;
                        cur_in     = clamp_cur;
                        base_ok_in = base_ok_ff && !clamp_hit;
                        if (pos_ff < start0_ff) begin
                           rsp_valid_in        = 1'b1;
                           rsp_in.row_index    = '0;
                           rsp_in.table_id     = '0;
                           rsp_in.miss         = 1'b1;
                           rsp_in.out_position = pos_ff;
                           pos_in              = pos_ff + 1'b1;
                        end else begin
                           walk     = 1'b1;
                           walk_cur = clamp_cur;
                           walk_ok  = base_ok_ff && !clamp_hit;
                           walk_idx = q_head.index_value;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHECK: begin
            walk = 1'b1;
            if (ram_rd_data.start <= pos_ff) begin
               cur_in     = cur_ff + 1'b1;
               base_in    = ram_rd_data.row_base;
               base_ok_in = 1'b1;
               walk_cur   = cur_ff + 1'b1;
               walk_ok    = 1'b1;
               walk_base  = ram_rd_data.row_base;
            end else begin
               walk_search = 1'b0;
            end
         end
         S_BASE: begin
            base_in    = ram_rd_data.row_base;
            base_ok_in = 1'b1;
            walk       = 1'b1;
            walk_ok    = 1'b1;
            walk_base  = ram_rd_data.row_base;
            walk_search = 1'b0;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (walk) begin
         if (walk_search && (32'(walk_cur) + 32'd1 < 32'(num_tables))) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = walk_cur + 1'b1;
            state_in    = S_CHECK;
         end else if (walk_ok) begin
            rsp_valid_in        = 1'b1;
            rsp_in.row_index    = 33'(walk_idx) + 33'(walk_base);
            rsp_in.table_id     = 10'(walk_cur);
            rsp_in.miss         = 1'b0;
            rsp_in.out_position = pos_ff;
            pos_in              = pos_ff + 1'b1;
            state_in            = S_IDLE;
         end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = walk_cur;
            state_in    = S_BASE;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         pos_ff       <= '0;
         start0_ff    <= '0;
         base_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         start0_ff    <= start0_in;
         base_ok_ff   <= base_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   erag_ram #(
      .WIDTH (erag_pkg::ENTRY_W),
      .DEPTH (erag_pkg::MAX_TABLES)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   `ERAG_ASSERT_IMPL(a_pop_only_idle, q_pop, state_ff == S_IDLE)
   `ERAG_ASSERT_IMPL(a_check_in_range, state_ff == S_CHECK,
                     32'(cur_ff) + 32'd1 < 32'(num_tables))
   `ERAG_ASSERT_NEXT(a_base_emits, state_ff == S_BASE, rsp_valid_ff && !rsp_ff.miss)

endmodule

`default_nettype wire

// ----- hw/rtl/embedding_row_address_gen_core.sv -----
`default_nettype none

// Row address generator for batched multi-table embedding lookups. A transaction
// is taken when start is high and busy is low; results appear for exactly one
// cycle with rsp_strobe and cannot be held off, so the receiver must take every
// strobe. A front stage classifies transactions and runs a one-bit-per-cycle
// divider for loads, which keeps busy high from when a load is taken until its
// command is pushed (and while the queue is full), then hands commands to a
// 4-deep queue. The back sequencer owns the table store (one write and one
// registered read port) and the stream state. Loads, restarts, ignored commands
// and misses are handled as they are popped. A lookup reads and compares the
// next table's start once per table advanced, and once more unless it ends in
// the last table in use, then fetches the row base when no table was advanced
// and the base is not cached (after a load, a restart or a clamp of the current
// table). The store is not cleared by reset, so tables must be loaded before
// lookups read them.
module embedding_row_address_gen_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire erag_pkg::req_type                   req_payload,
   output logic                                     busy,
   output logic                                     rsp_strobe,
   output erag_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [erag_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [erag_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [erag_pkg::NUM_TABLES_W-1:0]   num_tables_ff;
   logic [erag_pkg::EMBED_DIM_W-1:0]    embed_dim_ff;

   erag_pkg::queue_status_type          q_status;
   erag_pkg::cmd_type                   q_head;
   erag_pkg::cmd_type                   q_push_data;
   logic                                q_push;
   logic                                q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_tables_ff <= erag_pkg::NUM_TABLES_W'(1);
         embed_dim_ff  <= erag_pkg::EMBED_DIM_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            erag_pkg::CSR_NUM_TABLES: num_tables_ff <= csr_wdata[erag_pkg::NUM_TABLES_W-1:0];
            erag_pkg::CSR_EMBED_DIM:  embed_dim_ff  <= csr_wdata[erag_pkg::EMBED_DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   erag_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .embed_dim   (embed_dim_ff),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   erag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .status    (q_status),
      .head      (q_head)
   );

   erag_back u_back (
      .clock       (clock),
      .reset       (reset),
      .num_tables  (num_tables_ff),
      .q_status    (q_status),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- dv/tb_embedding_row_address_gen_core.sv -----
`default_nettype none

module tb_embedding_row_address_gen_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int ITEM_TARGET  = 1650;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic                            clock;
   logic                            reset;
   logic                            start;
   erag_pkg::req_type               req_payload;
   logic                            busy;
   logic                            rsp_strobe;
   erag_pkg::rsp_type               rsp_payload;
   logic                            csr_we;
   logic [erag_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [erag_pkg::CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   bit [30:0] tbl_start    [erag_pkg::MAX_TABLES];
   bit [31:0] tbl_row_base [erag_pkg::MAX_TABLES];
   bit        tbl_loaded   [erag_pkg::MAX_TABLES];
   int        cur_tbl;
   bit [30:0] stream_pos;
   int        cfg_num_tables;
   bit [15:0] cfg_embed_dim;

   erag_pkg::rsp_type pending_rows [$];
   erag_pkg::rsp_type expected_row;
   int        mismatch_count;
   int        items_sent;
   int        burst_left;
   int        cycle_count;

   embedding_row_address_gen_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // results cannot be held off: every strobe is taken at the edge ending its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rows.size() == 0) begin
            $display("%0t: result with no lookup pending: expected none, got %p",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            expected_row = pending_rows.pop_front();
            if (rsp_payload.row_index !== expected_row.row_index ||
                rsp_payload.table_id !== expected_row.table_id ||
                rsp_payload.miss !== expected_row.miss ||
                rsp_payload.out_position !== expected_row.out_position) begin
               $display("%0t: expected row %h table %0d miss %b pos %h", $time,
                        expected_row.row_index, expected_row.table_id,
                        expected_row.miss, expected_row.out_position);
               $display("%0t:   actual row %h table %0d miss %b pos %h", $time,
                        rsp_payload.row_index, rsp_payload.table_id,
                        rsp_payload.miss, rsp_payload.out_position);
               mismatch_count++;
            end
         end
      end
   end

   task automatic predict_address(input erag_pkg::req_type item);
      erag_pkg::rsp_type row;
      bit [31:0] divisor;
      case (item.func)
         erag_pkg::FUNC_LOAD: begin
            divisor = (cfg_embed_dim == 16'd0) ? 32'd1 : {16'd0, cfg_embed_dim};
            tbl_start[item.table_number]    = item.position_value;
            tbl_row_base[item.table_number] = item.weight_offset / divisor;
            tbl_loaded[item.table_number]   = 1'b1;
         end
         erag_pkg::FUNC_RESTART: begin
            stream_pos = item.position_value;
            cur_tbl    = 0;
         end
         erag_pkg::FUNC_LOOKUP: begin
            if (cfg_num_tables >= 1 && cfg_num_tables <= erag_pkg::MAX_TABLES) begin
               // count may have been lowered since the table was selected
               if (cur_tbl >= cfg_num_tables)
                  cur_tbl = cfg_num_tables - 1;
               row = '0;
               row.out_position = stream_pos;
               if (stream_pos < tbl_start[0]) begin
                  row.miss = 1'b1;
               end else begin
                  while (cur_tbl + 1 < cfg_num_tables && tbl_start[cur_tbl + 1] <= stream_pos)
                     cur_tbl++;
                  row.table_id  = 10'(cur_tbl);
                  row.row_index = 33'(item.index_value) + 33'(tbl_row_base[cur_tbl]);
               end
               stream_pos = stream_pos + 31'd1;
               pending_rows.push_back(row);
            end
         end
         default: ;
      endcase
   endtask

   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(10, 50);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   // start stays high after a transaction; the next call lowers it only for a gap, and the drain lowers it
   task automatic send_item(input erag_pkg::req_type item);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      predict_address(item);
      if (item.func != FUNC_UNUSED)
         items_sent++;
   endtask

   function automatic erag_pkg::req_type random_item(input logic [1:0] op);
      erag_pkg::req_type item;
      item.func           = op;
      item.table_number   = 10'($urandom);
      item.position_value = 31'($urandom);
      item.weight_offset  = $urandom;
      item.index_value    = 31'($urandom);
      return item;
   endfunction

   function automatic bit [30:0] random_index();
      case ($urandom_range(0, 5))
         0:       return 31'd0;
         1:       return 31'h7FFF_FFFF;
         2, 3:    return 31'($urandom);
         default: return 31'($urandom_range(0, 1000));
      endcase
   endfunction

   function automatic bit [31:0] random_offset();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(0, 100000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_load(input int tnum, input bit [30:0] pos, input bit [31:0] woff);
      erag_pkg::req_type item;
      item = random_item(erag_pkg::FUNC_LOAD);
      item.table_number   = 10'(tnum);
      item.position_value = pos;
      item.weight_offset  = woff;
      send_item(item);
   endtask

   task automatic send_lookup(input bit [30:0] idx);
      erag_pkg::req_type item;
      item = random_item(erag_pkg::FUNC_LOOKUP);
      item.index_value = idx;
      send_item(item);
   endtask

   task automatic send_restart(input bit [30:0] pos);
      erag_pkg::req_type item;
      item = random_item(erag_pkg::FUNC_RESTART);
      item.position_value = pos;
      send_item(item);
   endtask

   // loads are not answered, so after the last result give the divider time to finish
   task automatic wait_until_idle();
      start <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input int nt, input bit [15:0] dim);
      wait_until_idle();
      csr_we    <= 1'b1;
      csr_index <= erag_pkg::CSR_NUM_TABLES;
      csr_wdata <= 16'(nt);
      @(posedge clock);
      csr_index <= erag_pkg::CSR_EMBED_DIM;
      csr_wdata <= dim;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_num_tables = nt;
      cfg_embed_dim  = dim;
   endtask

   // loads tables 0..count-1; ascending starts unless scrambled
   task automatic fill_store(input int count, input bit [30:0] first, input int max_step,
                             input bit scrambled);
      bit [30:0] pos;
      pos = first;
      for (int t = 0; t < count; t++) begin
         if (scrambled)
            pos = first + 31'($urandom_range(0, 8 * count));
         send_load(t, pos, random_offset());
         if ($urandom_range(0, 7) == 0)
            pos = pos + 31'($urandom_range(0, 1 << 16));
         else
            pos = pos + 31'($urandom_range(0, max_step));
      end
   endtask

   task automatic test_directed_cases();
      set_config(4, 16'd7);
      send_load(0, 31'd5, 32'hFFFF_FFFF);
      send_load(1, 31'd8, 32'd0);
      send_load(2, 31'd8, 32'd100);        // same start as table 1: table 1 is empty
      send_load(3, 31'h7FFF_FFFF, 32'd12345);
      send_lookup(31'h7FFF_FFFF);          // position 0 is before table 0
      send_restart(31'd5);
      send_lookup(31'h7FFF_FFFF);          // max index plus table 0's base, no carry into bit 32
      send_lookup(31'd0);
      send_lookup(31'd1);
      send_lookup(31'd2);                  // position 8 skips table 1
      send_restart(31'h7FFF_FFFE);
      send_lookup(31'd3);
      send_lookup(31'd4);                  // last table
      send_lookup(31'd5);                  // position wrapped to 0
      send_item(random_item(FUNC_UNUSED));
      set_config(0, 16'd0);
      send_lookup(31'd6);                  // no tables
      send_load(0, 31'd0, 32'hFFFF_FFFF);  // zero divisor behaves as 1
      set_config(2047, 16'd0);
      send_lookup(31'd7);
      set_config(1025, 16'hFFFF);
      send_lookup(31'd8);
      send_load(1, 31'd3, 32'hFFFF_FFFF);
      set_config(2, 16'hFFFF);
      send_lookup(31'h7FFF_FFFF);          // current table 3 clamps to 1
      set_config(1, 16'd1);
      send_lookup(31'd9);
   endtask

   task automatic test_full_store();
      bit [30:0] pos;
      set_config(erag_pkg::MAX_TABLES, 16'($urandom_range(1, 300)));
      fill_store(erag_pkg::MAX_TABLES, 31'($urandom_range(0, 3)), 2, 1'b0);
      send_restart(31'd0);
      repeat (60) begin
         case ($urandom_range(0, 5))
            0: begin
               pos = 31'($urandom_range(0, 32'(tbl_start[erag_pkg::MAX_TABLES - 1]) + 16));
               send_restart(pos);
            end
            1: send_restart(31'h7FFF_FFFF - 31'($urandom_range(0, 1)));
            default: send_lookup(random_index());
         endcase
      end
   endtask

   task automatic test_random_streams(input int target);
      int        first_count;
      int        nt;
      int        roll;
      int        t;
      bit [15:0] dim;
      bit        valid;
      bit        need_fill;
      bit [30:0] pos;
      first_count = items_sent;
      while (items_sent - first_count < target) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            case ($urandom_range(0, 3))
               0:       nt = 0;
               1:       nt = erag_pkg::MAX_TABLES + 1;
               2:       nt = 2047;
               default: nt = $urandom_range(erag_pkg::MAX_TABLES + 2, 2046);
            endcase
         end else if (roll <= 2) begin
            nt = 1;
         end else if (roll <= 12) begin
            nt = $urandom_range(2, 8);
         end else if (roll <= 17) begin
            nt = $urandom_range(9, 40);
         end else begin
            nt = $urandom_range(41, 128);
         end
         case ($urandom_range(0, 9))
            0:       dim = 16'd0;
            1:       dim = 16'd1;
            2:       dim = 16'hFFFF;
            3, 4, 5: dim = 16'($urandom_range(2, 16));
            default: dim = 16'($urandom);
         endcase
         set_config(nt, dim);
         valid = (nt >= 1 && nt <= erag_pkg::MAX_TABLES);

         // every table in use must be loaded before any lookup reads it
         if (valid) begin
            need_fill = ($urandom_range(0, 9) < 6);
            for (t = 0; t < nt; t++)
               if (!tbl_loaded[t])
                  need_fill = 1'b1;
            if (need_fill) begin
               case ($urandom_range(0, 3))
                  0:       pos = 31'd0;
                  1:       pos = 31'($urandom_range(0, 200));
                  2:       pos = 31'($urandom);
                  default: pos = 31'h7FFF_FF00;
               endcase
               fill_store(nt, pos, $urandom_range(0, 6), $urandom_range(0, 9) == 0);
            end
         end
         // without a restart, the table left by the previous setting may get clamped
         if ($urandom_range(0, 1))
            send_restart(tbl_start[0] - 31'($urandom_range(0, 3)));

         repeat ($urandom_range(20, 90)) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
               send_lookup(random_index());
            end else if (roll < 82) begin
               t = valid ? $urandom_range(0, nt - 1)
                         : $urandom_range(0, erag_pkg::MAX_TABLES - 1);
               case ($urandom_range(0, 3))
                  0:       pos = 31'($urandom);
                  1:       pos = 31'h7FFF_FFFF - 31'($urandom_range(0, 2));
                  default: pos = tbl_start[t] + 31'($urandom_range(0, 4)) - 31'd2;
               endcase
               send_restart(pos);
            end else if (roll < 94) begin
               if (valid && $urandom_range(0, 3) != 0)
                  t = $urandom_range(0, nt - 1);
               else
                  t = $urandom_range(0, erag_pkg::MAX_TABLES - 1);
               send_load(t, tbl_start[t] + 31'($urandom_range(0, 6)) - 31'd3, random_offset());
            end else begin
               send_item(random_item(FUNC_UNUSED));
            end
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_payload    = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      cur_tbl        = 0;
      stream_pos     = '0;
      cfg_num_tables = 1;
      cfg_embed_dim  = 16'd1;
      mismatch_count = 0;
      items_sent     = 0;
      burst_left     = 0;
      cycle_count    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_store();
      // the full store already used most of the item budget
      test_random_streams(ITEM_TARGET - items_sent);

      wait_until_idle();
      if (mismatch_count == 0 && pending_rows.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/erag_pkg.sv
hw/rtl/erag_ram.sv
hw/rtl/erag_front.sv
hw/rtl/erag_queue.sv
hw/rtl/erag_back.sv
hw/rtl/embedding_row_address_gen_core.sv
dv/tb_embedding_row_address_gen_core.sv
